### rtl/tbc_pkg.sv
// Shared types and fixed constants of the triangle barycentric coordinate block.
package tbc_pkg;

  // Width of one input coordinate field on the port.
  localparam int IN_W = 16;

  // Width of one saturated weight on the port.
  localparam int OUT_BITS = 21;

  // Width of the inside-test tolerance register (unsigned Q0.16).
  localparam int TOL_W = 16;

  // Quotient magnitudes are clamped to two to the power of this bit.
  localparam int QCLAMP_BIT = 40;

  // Sideband that travels with an item through the divider.
  typedef struct packed {
    logic degen;
  } tag_t;

endpackage

### rtl/tbc_if.sv
// Valid/ready channel interfaces for query items and coordinate results.
interface tbc_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [tbc_pkg::IN_W-1:0] point_x;
  logic signed [tbc_pkg::IN_W-1:0] point_y;
  logic signed [tbc_pkg::IN_W-1:0] point_z;
  logic signed [tbc_pkg::IN_W-1:0] vert_a_x;
  logic signed [tbc_pkg::IN_W-1:0] vert_a_y;
  logic signed [tbc_pkg::IN_W-1:0] vert_a_z;
  logic signed [tbc_pkg::IN_W-1:0] vert_b_x;
  logic signed [tbc_pkg::IN_W-1:0] vert_b_y;
  logic signed [tbc_pkg::IN_W-1:0] vert_b_z;
  logic signed [tbc_pkg::IN_W-1:0] vert_c_x;
  logic signed [tbc_pkg::IN_W-1:0] vert_c_y;
  logic signed [tbc_pkg::IN_W-1:0] vert_c_z;

  modport source (
    output valid, point_x, point_y, point_z, vert_a_x, vert_a_y, vert_a_z,
           vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, point_z, vert_a_x, vert_a_y, vert_a_z,
           vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z,
    output ready
  );
endinterface

interface tbc_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [tbc_pkg::OUT_BITS-1:0] coord_u;
  logic signed [tbc_pkg::OUT_BITS-1:0] coord_v;
  logic signed [tbc_pkg::OUT_BITS-1:0] coord_w;
  logic                                 inside_res;
  logic                                 degenerate;
  logic                                 saturated;

  modport source (
    output valid, coord_u, coord_v, coord_w, inside_res, degenerate, saturated,
    input  ready
  );
  modport sink (
    input  valid, coord_u, coord_v, coord_w, inside_res, degenerate, saturated,
    output ready
  );
endinterface

### rtl/tbc_div.sv
// Pipelined restoring divider for the two weight numerators, one quotient bit per stage.
module tbc_div #(
  parameter int DW = 72,
  parameter int WF = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [DW-1:0]             num_u,
  input  logic signed [DW-1:0]             num_v,
  input  logic        [DW-1:0]             den,
  input  tbc_pkg::tag_t                    in_tag,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [tbc_pkg::QCLAMP_BIT+1:0] quo_u,
  output logic signed [tbc_pkg::QCLAMP_BIT+1:0] quo_v,
  output tbc_pkg::tag_t                    out_tag
);

  localparam int QB = tbc_pkg::QCLAMP_BIT + 1;
  localparam int QW = QB + 1;
  localparam int NW = DW + WF;
  localparam int RW = DW + 1;
  localparam int NS = QB + 3;
  localparam logic [QB-1:0] CLAMP = QB'(1) << (QB - 1);

  // Stage valids; stage 0 takes magnitudes, stage 1 the overflow check,
  // stages 2..QB+1 the quotient bits, the last one clamps and signs.
  logic [NS-1:0] vld;
  logic [NS:0]   adv;

  always_comb begin
    adv[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld[NS-1];

  // Valid bits move with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Magnitude stage: absolute numerator scaled by the weight fraction bits.
  logic [NW-1:0]    a_mag [2];
  logic [1:0]       a_neg;
  logic [DW-1:0]    a_den;
  tbc_pkg::tag_t    a_tag;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      a_mag[0] <= {(num_u[DW-1] ? -num_u : num_u), {WF{1'b0}}};
      a_mag[1] <= {(num_v[DW-1] ? -num_v : num_v), {WF{1'b0}}};
      a_neg    <= {num_v[DW-1], num_u[DW-1]};
      a_den    <= den;
      a_tag    <= in_tag;
    end
  end

  // Per-step state; index 0 is the overflow stage, index k+1 is quotient step k.
  logic [RW-1:0]    st_r   [QB+1][2];
  logic [QB-1:0]    st_q   [QB+1][2];
  logic [QB-1:0]    st_lo  [QB+1][2];
  logic [1:0]       st_ovf [QB+1];
  logic [1:0]       st_neg [QB+1];
  logic [DW-1:0]    st_den [QB+1];
  tbc_pkg::tag_t    st_tag [QB+1];

  // Overflow stage: quotient of at least 2^QB only needs the clamp.
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int l = 0; l < 2; l++) begin
        st_ovf[0][l] <= NW'(a_mag[l] >> QB) >= NW'(a_den);
        st_r[0][l]   <= RW'(a_mag[l] >> QB);
        st_q[0][l]   <= '0;
        st_lo[0][l]  <= a_mag[l][QB-1:0];
      end
      st_neg[0] <= a_neg;
      st_den[0] <= a_den;
      st_tag[0] <= a_tag;
    end
  end

  // One restoring step per stage.
  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [RW-1:0] trial [2];
    logic [1:0]    ge;

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        trial[l] = {st_r[k][l][RW-2:0], st_lo[k][l][QB-1-k]};
        ge[l]    = trial[l] >= RW'(st_den[k]);
      end
    end

    always_ff @(posedge clk) begin
      if (adv[k+2]) begin
        for (int l = 0; l < 2; l++) begin
          st_r[k+1][l]  <= ge[l] ? trial[l] - RW'(st_den[k]) : trial[l];
          st_q[k+1][l]  <= {st_q[k][l][QB-2:0], ge[l]};
          st_lo[k+1][l] <= st_lo[k][l];
        end
        st_ovf[k+1] <= st_ovf[k];
        st_neg[k+1] <= st_neg[k];
        st_den[k+1] <= st_den[k];
        st_tag[k+1] <= st_tag[k];
      end
    end
  end

  // Clamp the magnitude and restore the sign.
  logic [QB-1:0] mag [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (st_ovf[QB][l] || st_q[QB][l] > CLAMP) begin
        mag[l] = CLAMP;
      end else begin
        mag[l] = st_q[QB][l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[NS-1]) begin
      quo_u   <= st_neg[QB][0] ? -QW'(mag[0]) : QW'(mag[0]);
      quo_v   <= st_neg[QB][1] ? -QW'(mag[1]) : QW'(mag[1]);
      out_tag <= st_tag[QB];
    end
  end

endmodule

### rtl/triangle_barycentric_coords_top.sv
// Top level of the triangle barycentric coordinate pipeline.
// Each transfer on item carries a point and a triangle; exactly one result per item leaves on
// result, in order. The block is a fully pipelined datapath that takes one item every cycle
// when result does not stall; the depth of the pipeline is set mainly by the divider,
// which resolves one of the 41 quotient bits per stage for both weights in parallel. Six
// stages form the differences, cross products and dot products, two stages after the divider
// saturate the weights and run the inside test. Each stage holds its item while the next one
// is full, so stalls on result lose nothing and bubbles close up. The tolerance register is
// written through cfg_we/cfg_wdata and should only change while no item is in flight.
module triangle_barycentric_coords_top #(
  parameter int COORD_BITS       = 16,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  tbc_in_if.sink                    item,
  tbc_out_if.source                 result,
  input  logic                      cfg_we,
  input  logic [tbc_pkg::TOL_W-1:0] cfg_wdata
);

  localparam int CB   = COORD_BITS;
  localparam int WF   = WEIGHT_FRAC_BITS;
  localparam int D    = CB + 1;
  localparam int PW   = 2 * D;
  localparam int CR   = PW + 1;
  localparam int DPW  = 2 * CR;
  localparam int DW   = DPW + 2;
  localparam int QW   = tbc_pkg::QCLAMP_BIT + 2;
  localparam int WW   = QW + 2;
  localparam int OB   = tbc_pkg::OUT_BITS;
  localparam int TW   = tbc_pkg::TOL_W;
  localparam int CMPW = ((OB > WF + 2) ? OB : WF + 2) + 1;
  localparam int NF   = 6;

  localparam logic signed [WW-1:0]   SAT_HI = (WW'(1) <<< (OB - 1)) - WW'(1);
  localparam logic signed [WW-1:0]   SAT_LO = -(WW'(1) <<< (OB - 1));
  localparam logic signed [WW-1:0]   ONE_W  = WW'(1) <<< WF;
  localparam logic signed [CMPW-1:0] ONE_C  = CMPW'(1) <<< WF;

  // Tolerance register.
  logic [TW-1:0] tolerance;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= '0;
    end else if (cfg_we) begin
      tolerance <= cfg_wdata;
    end
  end

  // Front pipeline handshake.
  logic [NF-1:0] fvld;
  logic [NF:0]   fadv;
  logic          div_in_ready;

  always_comb begin
    fadv[NF] = div_in_ready;
    for (int k = NF - 1; k >= 0; k--) begin
      fadv[k] = !fvld[k] || fadv[k+1];
    end
  end

  assign item.ready = fadv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      fvld <= '0;
    end else begin
      if (fadv[0]) begin
        fvld[0] <= item.valid;
      end
      for (int k = 1; k < NF; k++) begin
        if (fadv[k]) begin
          fvld[k] <= fvld[k-1];
        end
      end
    end
  end

  // Stage F0: take the low COORD_BITS of each field as a signed value.
  logic signed [CB-1:0] f0_p [3];
  logic signed [CB-1:0] f0_a [3];
  logic signed [CB-1:0] f0_b [3];
  logic signed [CB-1:0] f0_c [3];

  always_ff @(posedge clk) begin
    if (fadv[0]) begin
      f0_p[0] <= signed'(CB'($unsigned(item.point_x)));
      f0_p[1] <= signed'(CB'($unsigned(item.point_y)));
      f0_p[2] <= signed'(CB'($unsigned(item.point_z)));
      f0_a[0] <= signed'(CB'($unsigned(item.vert_a_x)));
      f0_a[1] <= signed'(CB'($unsigned(item.vert_a_y)));
      f0_a[2] <= signed'(CB'($unsigned(item.vert_a_z)));
      f0_b[0] <= signed'(CB'($unsigned(item.vert_b_x)));
      f0_b[1] <= signed'(CB'($unsigned(item.vert_b_y)));
      f0_b[2] <= signed'(CB'($unsigned(item.vert_b_z)));
      f0_c[0] <= signed'(CB'($unsigned(item.vert_c_x)));
      f0_c[1] <= signed'(CB'($unsigned(item.vert_c_y)));
      f0_c[2] <= signed'(CB'($unsigned(item.vert_c_z)));
    end
  end

  // Stage F1: edge and point differences. Cross j uses lhs[j] x rhs[j]:
  // the triangle normal, then the two sub-triangle normals at the point.
  logic signed [D-1:0] lhs [3][3];
  logic signed [D-1:0] rhs [3][3];

  always_ff @(posedge clk) begin
    if (fadv[1]) begin
      for (int i = 0; i < 3; i++) begin
        lhs[0][i] <= D'(f0_b[i]) - D'(f0_a[i]);
        rhs[0][i] <= D'(f0_c[i]) - D'(f0_a[i]);
        lhs[1][i] <= D'(f0_b[i]) - D'(f0_p[i]);
        rhs[1][i] <= D'(f0_c[i]) - D'(f0_p[i]);
        lhs[2][i] <= D'(f0_c[i]) - D'(f0_p[i]);
        rhs[2][i] <= D'(f0_a[i]) - D'(f0_p[i]);
      end
    end
  end

  // Stage F2: the two products of each cross product component.
  logic signed [PW-1:0] f2_m [3][3][2];

  for (genvar j = 0; j < 3; j++) begin : g_cross
    for (genvar i = 0; i < 3; i++) begin : g_comp
      localparam int I1 = (i + 1) % 3;
      localparam int I2 = (i + 2) % 3;
      always_ff @(posedge clk) begin
        if (fadv[2]) begin
          f2_m[j][i][0] <= PW'(lhs[j][I1]) * PW'(rhs[j][I2]);
          f2_m[j][i][1] <= PW'(lhs[j][I2]) * PW'(rhs[j][I1]);
        end
      end
    end
  end

  // Stage F3: cross product components.
  logic signed [CR-1:0] f3_x [3][3];

  always_ff @(posedge clk) begin
    if (fadv[3]) begin
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < 3; i++) begin
          f3_x[j][i] <= CR'(f2_m[j][i][0]) - CR'(f2_m[j][i][1]);
        end
      end
    end
  end

  // Stage F4: dot product terms of the normal with each of the three normals.
  logic signed [DPW-1:0] f4_d [3][3];

  always_ff @(posedge clk) begin
    if (fadv[4]) begin
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < 3; i++) begin
          f4_d[j][i] <= DPW'(f3_x[0][i]) * DPW'(f3_x[j][i]);
        end
      end
    end
  end

  // Stage F5: squared normal length and the two weight numerators.
  logic signed [DW-1:0] f5_s [3];
  logic signed [DW-1:0] dsum [3];
  tbc_pkg::tag_t        f5_tag;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      dsum[j] = DW'(f4_d[j][0]) + DW'(f4_d[j][1]) + DW'(f4_d[j][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (fadv[5]) begin
      f5_s         <= dsum;
      f5_tag.degen <= dsum[0] == '0;
    end
  end

  // Divider for both weights.
  logic                 div_out_valid;
  logic                 div_out_ready;
  logic signed [QW-1:0] quo_u;
  logic signed [QW-1:0] quo_v;
  tbc_pkg::tag_t        div_tag;

  tbc_div #(
    .DW (DW),
    .WF (WF)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fvld[NF-1]),
    .in_ready  (div_in_ready),
    .num_u     (f5_s[1]),
    .num_v     (f5_s[2]),
    .den       ($unsigned(f5_s[0])),
    .in_tag    (f5_tag),
    .out_valid (div_out_valid),
    .out_ready (div_out_ready),
    .quo_u     (quo_u),
    .quo_v     (quo_v),
    .out_tag   (div_tag)
  );

  // Back pipeline handshake: saturation stage, then the output register.
  logic p0_vld;
  logic p1_vld;
  logic p0_adv;
  logic p1_adv;

  assign p1_adv        = !p1_vld || result.ready;
  assign p0_adv        = !p0_vld || p1_adv;
  assign div_out_ready = p0_adv;
  assign result.valid  = p1_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      p0_vld <= 1'b0;
      p1_vld <= 1'b0;
    end else begin
      if (p0_adv) begin
        p0_vld <= div_out_valid;
      end
      if (p1_adv) begin
        p1_vld <= p0_vld;
      end
    end
  end

  // Stage P0: third weight from the unclipped quotients, then saturation.
  logic signed [WW-1:0] wide [3];
  logic signed [OB-1:0] satv [3];
  logic [2:0]           clip;
  logic signed [OB-1:0] p0_w [3];
  logic                 p0_sat;
  logic                 p0_degen;

  always_comb begin
    wide[0] = WW'(quo_u);
    wide[1] = WW'(quo_v);
    wide[2] = ONE_W - WW'(quo_u) - WW'(quo_v);
    for (int j = 0; j < 3; j++) begin
      if (wide[j] > SAT_HI) begin
        satv[j] = OB'(SAT_HI);
        clip[j] = 1'b1;
      end else if (wide[j] < SAT_LO) begin
        satv[j] = OB'(SAT_LO);
        clip[j] = 1'b1;
      end else begin
        satv[j] = OB'(wide[j]);
        clip[j] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p0_adv) begin
      for (int j = 0; j < 3; j++) begin
        p0_w[j] <= div_tag.degen ? '0 : satv[j];
      end
      p0_sat   <= !div_tag.degen && (clip != '0);
      p0_degen <= div_tag.degen;
    end
  end

  // Tolerance rescaled to the weight fraction bits.
  logic signed [CMPW-1:0] eps;

  if (WF >= TW) begin : g_eps_up
    assign eps = CMPW'(tolerance) << (WF - TW);
  end else begin : g_eps_down
    assign eps = CMPW'(tolerance >> (TW - WF));
  end

  // Stage P1: inside test into the output register.
  logic [2:0]           in_range;
  logic signed [OB-1:0] r_w [3];
  logic                 r_inside;
  logic                 r_degen;
  logic                 r_sat;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      in_range[j] = (CMPW'(p0_w[j]) >= -eps) && (CMPW'(p0_w[j]) <= ONE_C + eps);
    end
  end

  always_ff @(posedge clk) begin
    if (p1_adv) begin
      r_w      <= p0_w;
      r_inside <= !p0_degen && (in_range == '1);
      r_degen  <= p0_degen;
      r_sat    <= p0_sat;
    end
  end

  assign result.coord_u    = r_w[0];
  assign result.coord_v    = r_w[1];
  assign result.coord_w    = r_w[2];
  assign result.inside_res = r_inside;
  assign result.degenerate = r_degen;
  assign result.saturated  = r_sat;

endmodule

### tb/triangle_barycentric_coords_top_tb.sv
// Self-checking testbench for the triangle barycentric coordinate pipeline.
module triangle_barycentric_coords_top_tb;

  typedef struct packed {
    logic signed [tbc_pkg::IN_W-1:0] x;
    logic signed [tbc_pkg::IN_W-1:0] y;
    logic signed [tbc_pkg::IN_W-1:0] z;
  } vec_t;

  typedef struct packed {
    vec_t p;
    vec_t a;
    vec_t b;
    vec_t c;
  } query_t;

  typedef struct packed {
    logic signed [tbc_pkg::OUT_BITS-1:0] u;
    logic signed [tbc_pkg::OUT_BITS-1:0] v;
    logic signed [tbc_pkg::OUT_BITS-1:0] w;
    logic                                in_tri;
    logic                                degen;
    logic                                clipped;
  } weights_t;

  localparam int  FRAC       = 16;
  localparam int  RUN_LIMIT  = 400000;
  localparam int  LATENCY    = tbc_pkg::QCLAMP_BIT + 12;

  // Cross product of two small integer vectors.
  function automatic void cross3(input longint s[3], input longint t[3],
                                 output longint o[3]);
    o[0] = s[1] * t[2] - s[2] * t[1];
    o[1] = s[2] * t[0] - s[0] * t[2];
    o[2] = s[0] * t[1] - s[1] * t[0];
  endfunction

  // Exact dot product, widened so nothing wraps.
  function automatic logic signed [127:0] dot3(input longint s[3], input longint t[3]);
    logic signed [127:0] sum;
    logic signed [127:0] x;
    logic signed [127:0] y;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      x = s[i];
      y = t[i];
      sum += x * y;
    end
    return sum;
  endfunction

  // Truncated quotient num * 2^FRAC / den, magnitude clamped to 2^QCLAMP_BIT.
  function automatic longint scaled_quotient(input logic signed [127:0] num,
                                             input logic signed [127:0] den);
    logic [127:0] mag;
    logic [127:0] qt;
    bit           neg;
    neg = num < 0;
    mag = neg ? -num : num;
    qt  = (mag << FRAC) / den;
    if (qt > (128'd1 << tbc_pkg::QCLAMP_BIT)) qt = 128'd1 << tbc_pkg::QCLAMP_BIT;
    return neg ? -longint'(qt[63:0]) : longint'(qt[63:0]);
  endfunction

  function automatic logic signed [tbc_pkg::OUT_BITS-1:0] clip_weight(input longint x,
                                                                      inout bit flag);
    longint hi;
    longint lo;
    hi = (longint'(1) << (tbc_pkg::OUT_BITS - 1)) - 1;
    lo = -(longint'(1) << (tbc_pkg::OUT_BITS - 1));
    if (x > hi) begin
      flag = 1;
      return hi[tbc_pkg::OUT_BITS-1:0];
    end
    if (x < lo) begin
      flag = 1;
      return lo[tbc_pkg::OUT_BITS-1:0];
    end
    return x[tbc_pkg::OUT_BITS-1:0];
  endfunction

  // Barycentric weights of the point against the triangle.
  function automatic weights_t barycentric(input query_t q,
                                           input logic [tbc_pkg::TOL_W-1:0] tol);
    longint pt[3], va[3], vb[3], vc[3];
    longint ba[3], ca[3], bp[3], cp[3], ap[3];
    longint nrm[3], nbc[3], nca[3];
    logic signed [127:0] den;
    longint ur, vr, one, eps, su, sv, sw;
    bit flag;
    weights_t r;
    pt = '{q.p.x, q.p.y, q.p.z};
    va = '{q.a.x, q.a.y, q.a.z};
    vb = '{q.b.x, q.b.y, q.b.z};
    vc = '{q.c.x, q.c.y, q.c.z};
    for (int i = 0; i < 3; i++) begin
      ba[i] = vb[i] - va[i];
      ca[i] = vc[i] - va[i];
      bp[i] = vb[i] - pt[i];
      cp[i] = vc[i] - pt[i];
      ap[i] = va[i] - pt[i];
    end
    cross3(ba, ca, nrm);
    cross3(bp, cp, nbc);
    cross3(cp, ap, nca);
    den  = dot3(nrm, nrm);
    r    = '0;
    flag = 0;
    if (den == 0) begin
      r.degen = 1;
      return r;
    end
    one = longint'(1) << FRAC;
    ur  = scaled_quotient(dot3(nrm, nbc), den);
    vr  = scaled_quotient(dot3(nrm, nca), den);
    r.u = clip_weight(ur, flag);
    r.v = clip_weight(vr, flag);
    r.w = clip_weight(one - ur - vr, flag);
    r.clipped = flag;
    eps = longint'(tol) << (FRAC - 16);
    su  = longint'(r.u);
    sv  = longint'(r.v);
    sw  = longint'(r.w);
    r.in_tri = su >= -eps && su <= one + eps && sv >= -eps && sv <= one + eps &&
               sw >= -eps && sw <= one + eps;
    return r;
  endfunction

  // Holds the weights still owed by the block, oldest first.
  class weight_scoreboard;
    weights_t                  owed_q[$];
    logic [tbc_pkg::TOL_W-1:0] tol;
    int                        errors;
    int                        queries;
    int                        checked;
    int                        degen_seen;
    int                        clip_seen;
    int                        inside_seen;

    function new();
      tol = '0;
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch %0s: got %0d, expected %0d (result %0d)", what, got, want, checked);
      errors++;
    endtask

    function void note_query(query_t q);
      owed_q.push_back(barycentric(q, tol));
      queries++;
    endfunction

    task check_result(weights_t got);
      weights_t want;
      if (owed_q.size() == 0) begin
        $display("unexpected result with nothing outstanding");
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (got.u !== want.u) report("coord_u", got.u, want.u);
      if (got.v !== want.v) report("coord_v", got.v, want.v);
      if (got.w !== want.w) report("coord_w", got.w, want.w);
      if (got.in_tri !== want.in_tri) report("inside_res", got.in_tri, want.in_tri);
      if (got.degen !== want.degen) report("degenerate", got.degen, want.degen);
      if (got.clipped !== want.clipped) report("saturated", got.clipped, want.clipped);
      degen_seen  += want.degen;
      clip_seen   += want.clipped;
      inside_seen += want.in_tri;
      checked++;
    endtask
  endclass

  logic clk = 0;
  logic rst;
  logic cfg_we;
  logic [tbc_pkg::TOL_W-1:0] cfg_wdata;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  logic        hold_off;
  longint      cycles;
  weight_scoreboard sb = new();

  tbc_in_if  item ();
  tbc_out_if result ();

  triangle_barycentric_coords_top DUT (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Receiver side: random stalls, plus a long hold-off when asked.
  always @(posedge clk) begin
    result.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare every result transfer against the oldest owed weights.
  always @(posedge clk) begin
    if (!rst && result.valid && result.ready)
      sb.check_result('{result.coord_u, result.coord_v, result.coord_w,
                        result.inside_res, result.degenerate, result.saturated});
  end

  // Run limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic vec_t vec(int x, int y, int z);
    vec_t r;
    r.x = x[15:0];
    r.y = y[15:0];
    r.z = z[15:0];
    return r;
  endfunction

  function automatic vec_t rand_vec(int span, vec_t base);
    return vec(base.x + $signed($urandom_range(2 * span)) - span,
               base.y + $signed($urandom_range(2 * span)) - span,
               base.z + $signed($urandom_range(2 * span)) - span);
  endfunction

  // Random query: mostly proper triangles with a nearby point, some noise.
  function automatic query_t rand_query();
    query_t q;
    vec_t   ctr;
    int     span;
    case ($urandom_range(9))
      0, 1: q = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
      2: begin
        q = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
        if ($urandom_range(1)) q.b = q.a;
        else q.c = vec(2 * q.b.x - q.a.x, 2 * q.b.y - q.a.y, 2 * q.b.z - q.a.z);
      end
      3: begin
        ctr = rand_vec(20000, vec(0, 0, 0));
        q.a = rand_vec(3, ctr);
        q.b = rand_vec(3, ctr);
        q.c = rand_vec(3, ctr);
        q.p = rand_vec(8000, ctr);
      end
      default: begin
        span = 1 << $urandom_range(12, 2);
        ctr  = rand_vec(16000, vec(0, 0, 0));
        q.a  = rand_vec(span, ctr);
        q.b  = rand_vec(span, ctr);
        q.c  = rand_vec(span, ctr);
        q.p  = rand_vec(span + span / 2, ctr);
      end
    endcase
    return q;
  endfunction

  // Offer one query and hold it until the block takes it.
  task send_query(query_t q);
    item.valid    <= 1;
    item.point_x  <= q.p.x;
    item.point_y  <= q.p.y;
    item.point_z  <= q.p.z;
    item.vert_a_x <= q.a.x;
    item.vert_a_y <= q.a.y;
    item.vert_a_z <= q.a.z;
    item.vert_b_x <= q.b.x;
    item.vert_b_y <= q.b.y;
    item.vert_b_z <= q.b.z;
    item.vert_c_x <= q.c.x;
    item.vert_c_y <= q.c.y;
    item.vert_c_z <= q.c.z;
    do @(posedge clk); while (!item.ready);
    sb.note_query(q);
    while ($urandom_range(99) < send_idle_pct) begin
      item.valid <= 0;
      @(posedge clk);
    end
  endtask

  task drain();
    item.valid <= 0;
    while (sb.owed_q.size() != 0) @(posedge clk);
  endtask

  // Tolerance write, only with nothing in flight.
  task write_tolerance(logic [tbc_pkg::TOL_W-1:0] val);
    drain();
    cfg_we    <= 1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    sb.tol = val;
  endtask

  task random_phase(int n);
    for (int i = 0; i < n; i++) send_query(rand_query());
  endtask

  initial begin
    query_t directed[$];
    rst           = 1;
    cfg_we        = 0;
    cfg_wdata     = '0;
    hold_off      = 0;
    cycles        = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    item.valid    = 0;
    {item.point_x, item.point_y, item.point_z, item.vert_a_x, item.vert_a_y, item.vert_a_z,
     item.vert_b_x, item.vert_b_y, item.vert_b_z, item.vert_c_x, item.vert_c_y,
     item.vert_c_z} = '0;
    result.ready  = 0;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed corners: extremes, degenerate shapes, vertices, centroid, clipping.
    directed.push_back('0);
    directed.push_back({4{vec(32767, 32767, 32767)}});
    directed.push_back({4{vec(-32768, -32768, -32768)}});
    directed.push_back({vec(0, 0, 0), vec(-32768, -32768, 0), vec(32767, -32768, 0),
                        vec(-32768, 32767, 0)});
    directed.push_back({vec(32767, 32767, 32767), vec(-32768, -32768, -32768),
                        vec(32767, -32768, 32767), vec(-32768, 32767, -32768)});
    directed.push_back({vec(-32768, 32767, -32768), vec(0, 0, 0), vec(32767, 0, 0),
                        vec(0, 32767, 0)});
    directed.push_back({vec(85, 85, 0), vec(0, 0, 0), vec(256, 0, 0), vec(0, 256, 0)});
    directed.push_back({vec(0, 0, 0), vec(0, 0, 0), vec(256, 0, 0), vec(0, 256, 0)});
    directed.push_back({vec(256, 0, 0), vec(0, 0, 0), vec(256, 0, 0), vec(0, 256, 0)});
    directed.push_back({vec(0, 256, 0), vec(0, 0, 0), vec(256, 0, 0), vec(0, 256, 0)});
    directed.push_back({vec(128, 128, 0), vec(0, 0, 0), vec(256, 0, 0), vec(0, 256, 0)});
    directed.push_back({vec(-1, 0, 0), vec(0, 0, 0), vec(256, 0, 0), vec(0, 256, 0)});
    directed.push_back({vec(300, 0, 77), vec(0, 0, 0), vec(256, 0, 0), vec(0, 256, 0)});
    directed.push_back({vec(5, 5, 5), vec(0, 0, 0), vec(256, 256, 256), vec(512, 512, 512)});
    directed.push_back({vec(32767, -32768, 0), vec(0, 0, 0), vec(1, 0, 0), vec(0, 1, 0)});
    directed.push_back({vec(-32768, 32767, 100), vec(1, 1, 1), vec(2, 1, 1), vec(1, 1, 2)});
    directed.push_back({vec(-32768, -32768, 0), vec(0, 0, 0), vec(1, 0, 0), vec(0, 1, 0)});
    directed.push_back({vec(10, 20, 30), vec(10, 20, 30), vec(10, 20, 30), vec(10, 20, 30)});
    directed.push_back({vec(0, 0, 0), vec(-256, 0, 0), vec(0, 0, 256), vec(0, 256, 0)});
    foreach (directed[i]) send_query(directed[i]);

    // Same inside checks again with the widest and a small margin.
    write_tolerance(16'hFFFF);
    for (int i = 5; i < 13; i++) send_query(directed[i]);
    write_tolerance(16'd1);
    for (int i = 6; i < 13; i++) send_query(directed[i]);

    // Sender idles lightly, receiver heavily; a long receiver hold-off mid-phase.
    send_idle_pct = 12;
    recv_idle_pct = 61;
    write_tolerance(16'd655);
    random_phase(300);
    fork
      begin
        hold_off <= 1;
        repeat (300) @(posedge clk);
        hold_off <= 0;
      end
    join_none
    random_phase(360);

    // Sender pauses until every owed result has come back.
    drain();
    send_idle_pct = 61;
    recv_idle_pct = 12;
    write_tolerance($urandom_range(65535));
    random_phase(660);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_tolerance(16'hFFFF);
    random_phase(340);
    write_tolerance(16'h0000);
    random_phase(340);

    drain();
    repeat (LATENCY + 8) @(posedge clk);
    $display("checked %0d results from %0d queries over several tolerance settings",
             sb.checked, sb.queries);
    $display("degenerate %0d, clipped %0d, inside %0d, errors %0d",
             sb.degen_seen, sb.clip_seen, sb.inside_seen, sb.errors);
    if (sb.errors == 0 && sb.owed_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
